// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL datapath. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/hftd_pkg.sv =====
// ----------------------------------------------------------------------------
// hftd_pkg
// Shared constants and controller/datapath interface types of the decoder.
// ----------------------------------------------------------------------------
package hftd_pkg;

    localparam int ALPHABET_DEF     = 256;
    localparam int WEIGHT_WIDTH_DEF = 40;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_CODED  = 2'd2;

    typedef struct packed {
        logic hdr;
        logic ent;
        logic scan;
        logic drain;
        logic scan_end;
        logic find;
        logic find_tail;
        logic rem_rd;
        logic rem_wr;
        logic merge;
        logic build_end;
        logic byte_load;
        logic walk;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic collect;
        logic ent_last;
        logic scan_last;
        logic multi;
        logic find_last;
        logic have_a;
        logic pool_empty;
        logic walk_ok;
        logic walk_end;
        logic flush_done;
    } t_sts;

endpackage

// ===== hw/rtl/huffman_tree_decoder.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// Static Huffman decoder over a byte alphabet with an on-chip tree build.
// ----------------------------------------------------------------------------
// A header transaction restarts the block; the frequency entries that follow
// are taken one per cycle. After the last entry the input stalls while the
// tree is built: a leaf scan over all 256 byte values plus, for each of the
// L-1 merges, two linear minimum searches over the live node pool. A coded
// byte then stalls the input through a walk of its bits, one step per bit
// that waits on the read of the tree node memory for that bit, and a hand-over
// of the last symbol; the walk ends early when the total is reached, and a
// full output stage holds the walk and the hand-over.
module huffman_tree_decoder #(
    parameter int ALPHABET     = hftd_pkg::ALPHABET_DEF,
    parameter int WEIGHT_WIDTH = hftd_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [30:0] i_total_count,
    input  logic [8:0]  i_entry_count,
    input  logic [7:0]  i_entry_symbol,
    input  logic [30:0] i_entry_weight,
    input  logic [7:0]  i_coded_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_symbol,
    output logic        o_last_of_run,
    output logic        o_stream_done
);
    hftd_pkg::t_cmd cmd;
    hftd_pkg::t_sts sts;

    hftd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    hftd_dp #(
        .ALPHABET     (ALPHABET),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_total_count  (i_total_count),
        .i_entry_count  (i_entry_count),
        .i_entry_symbol (i_entry_symbol),
        .i_entry_weight (i_entry_weight),
        .i_coded_byte   (i_coded_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_symbol       (o_symbol),
        .o_last_of_run  (o_last_of_run),
        .o_stream_done  (o_stream_done)
    );

endmodule

// ===== hw/rtl/hftd_ctrl.sv =====
// ----------------------------------------------------------------------------
// hftd_ctrl
// Sequencer: input acceptance, tree build steps and the per-bit walk.
// ----------------------------------------------------------------------------
module hftd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_kind,
    input  hftd_pkg::t_sts i_sts,
    output hftd_pkg::t_cmd o_cmd,
    output logic           o_in_stall
);
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN      = 4'd1;
    localparam logic [3:0] S_DRAIN     = 4'd2;
    localparam logic [3:0] S_SCAN_END  = 4'd3;
    localparam logic [3:0] S_FIND      = 4'd4;
    localparam logic [3:0] S_FIND_TAIL = 4'd5;
    localparam logic [3:0] S_REM_RD    = 4'd6;
    localparam logic [3:0] S_REM_WR    = 4'd7;
    localparam logic [3:0] S_MERGE     = 4'd8;
    localparam logic [3:0] S_BUILD_END = 4'd9;
    localparam logic [3:0] S_WALK      = 4'd10;
    localparam logic [3:0] S_FLUSH     = 4'd11;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == hftd_pkg::KIND_HEADER) begin
                        o_cmd.hdr = 1'b1;
                    end else if (i_kind == hftd_pkg::KIND_ENTRY && i_sts.collect) begin
                        o_cmd.ent = 1'b1;
                        if (i_sts.ent_last) n_state = S_SCAN;
                    end else if (i_kind == hftd_pkg::KIND_CODED && i_sts.walk_ok) begin
                        o_cmd.byte_load = 1'b1;
                        n_state = S_WALK;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                o_cmd.drain = 1'b1;
                n_state = S_SCAN_END;
            end
            S_SCAN_END: begin
                o_cmd.scan_end = 1'b1;
                n_state = i_sts.multi ? S_FIND : S_IDLE;
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                if (i_sts.find_last) n_state = S_FIND_TAIL;
            end
            S_FIND_TAIL: begin
                o_cmd.find_tail = 1'b1;
                n_state = S_REM_RD;
            end
            S_REM_RD: begin
                o_cmd.rem_rd = 1'b1;
                n_state = S_REM_WR;
            end
            S_REM_WR: begin
                o_cmd.rem_wr = 1'b1;
                n_state = i_sts.have_a ? S_MERGE : S_FIND;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state = i_sts.pool_empty ? S_BUILD_END : S_FIND;
            end
            S_BUILD_END: begin
                o_cmd.build_end = 1'b1;
                n_state = S_IDLE;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_end) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (i_sts.flush_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

// ===== hw/rtl/hftd_dp.sv =====
// ----------------------------------------------------------------------------
// hftd_dp
// Datapath: weight store, node pool, tree node memory, walk and output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module hftd_dp #(
    parameter int ALPHABET     = hftd_pkg::ALPHABET_DEF,
    parameter int WEIGHT_WIDTH = hftd_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hftd_pkg::t_cmd i_cmd,
    output hftd_pkg::t_sts o_sts,
    input  logic [30:0]    i_total_count,
    input  logic [8:0]     i_entry_count,
    input  logic [7:0]     i_entry_symbol,
    input  logic [30:0]    i_entry_weight,
    input  logic [7:0]     i_coded_byte,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_symbol,
    output logic           o_last_of_run,
    output logic           o_stream_done
);
    localparam int NDEP = 2 * ALPHABET - 1;
    localparam int NW   = $clog2(NDEP);
    localparam int SW   = $clog2(ALPHABET);
    localparam int PW   = $clog2(ALPHABET + 1);
    localparam int W    = WEIGHT_WIDTH;
    localparam int PEW  = W + NW + 8;
    localparam int NEW  = 2 * (NW + 8);

    // Collection and decode status.
    logic [ALPHABET-1:0] r_present;
    logic [30:0]         sw_mem [ALPHABET];
    logic [30:0]         r_w_q;
    logic [30:0]         r_expect, r_written;
    logic [8:0]          r_ent_exp, r_ent_seen;
    logic                r_collect, r_decode;
    logic [NW-1:0]       r_root, r_cur, n_cur, r_leaf_cnt, r_count;

    // Leaf scan.
    logic [7:0]          r_k, raw;
    logic                r_sv;
    logic [7:0]          r_ssym;

    // Pool of live nodes, entries {weight, node, symbol}.
    logic [PEW-1:0]      pool_mem [ALPHABET];
    logic [PEW-1:0]      r_pool_q, r_best, r_a;
    logic [PW-1:0]       r_psize;
    logic [SW-1:0]       r_j, r_best_idx, r_cmp_j, pool_raddr, pool_waddr;
    logic                r_cmp_v, r_best_v, r_have_a;
    logic                pool_we, better;
    logic [PEW-1:0]      pool_wdata;

    // Tree nodes, entries {left, left symbol, right, right symbol}.
    logic [NEW-1:0]      node_mem [NDEP];
    logic [NEW-1:0]      r_node_q;

    // Walk and output.
    logic [7:0]          r_byte;
    logic [2:0]          r_bit;
    logic                r_pend_v, r_fin;
    logic [7:0]          r_pend_sym;
    logic                r_out_v, r_out_last, r_out_done;
    logic [7:0]          r_out_sym;
    logic                out_free, c_leaf, blocked, fin_now, raw_ok;
    logic [NW-1:0]       c_node;
    logic [7:0]          c_sym;

    assign raw    = r_k ^ 8'h80;
    assign raw_ok = ({1'b0, raw} < 9'(ALPHABET)) && r_present[raw[SW-1:0]];

    assign better = !r_best_v
                 || (r_pool_q[PEW-1 -: W] < r_best[PEW-1 -: W])
                 || ((r_pool_q[PEW-1 -: W] == r_best[PEW-1 -: W])
                     && (r_pool_q[NW+7:8] < r_best[NW+7:8]));

    assign out_free = !r_out_v || !i_out_stall;
    assign c_node   = r_byte[7] ? r_node_q[NW+7:8] : r_node_q[NEW-1 -: NW];
    assign c_sym    = r_byte[7] ? r_node_q[7:0] : r_node_q[NW+15:NW+8];
    assign c_leaf   = c_node < r_leaf_cnt;
    assign blocked  = c_leaf && r_pend_v && !out_free;
    assign fin_now  = (r_written + 31'd1) == r_expect;

    always_comb begin
        n_cur = r_cur;
        if (i_cmd.walk && !blocked) n_cur = c_leaf ? r_root : c_node;
        else if (i_cmd.merge)       n_cur = r_count;
    end

    always_comb begin
        pool_raddr = i_cmd.rem_rd ? SW'(r_psize - PW'(1)) : r_j;
        pool_we    = 1'b0;
        pool_waddr = SW'(r_psize);
        pool_wdata = {{(W-31){1'b0}}, r_w_q, r_count, r_ssym};
        if ((i_cmd.scan || i_cmd.drain) && r_sv) begin
            pool_we = 1'b1;
        end else if (i_cmd.rem_wr) begin
            pool_we    = 1'b1;
            pool_waddr = r_best_idx;
            pool_wdata = r_pool_q;
        end else if (i_cmd.merge) begin
            pool_we    = 1'b1;
            pool_wdata = {W'(r_a[PEW-1 -: W] + r_best[PEW-1 -: W]), r_count, 8'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_w_q    <= sw_mem[raw[SW-1:0]];
        r_pool_q <= pool_mem[pool_raddr];
        r_node_q <= node_mem[n_cur];
        if (i_cmd.ent && ({1'b0, i_entry_symbol} < 9'(ALPHABET))) begin
            sw_mem[i_entry_symbol[SW-1:0]] <= i_entry_weight;
        end
        if (pool_we) pool_mem[pool_waddr] <= pool_wdata;
        if (i_cmd.merge) begin
            node_mem[r_count] <= {r_a[NW+7:0], r_best[NW+7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= '0;
            r_expect   <= '0;
            r_written  <= '0;
            r_ent_exp  <= '0;
            r_ent_seen <= '0;
            r_collect  <= 1'b0;
            r_decode   <= 1'b0;
            r_root     <= '0;
            r_cur      <= '0;
            r_leaf_cnt <= '0;
            r_count    <= '0;
            r_k        <= '0;
            r_sv       <= 1'b0;
            r_psize    <= '0;
            r_j        <= '0;
            r_cmp_v    <= 1'b0;
            r_best_v   <= 1'b0;
            r_have_a   <= 1'b0;
            r_bit      <= '0;
            r_pend_v   <= 1'b0;
            r_fin      <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_cur <= n_cur;
            if (r_out_v && !i_out_stall) r_out_v <= 1'b0;

            if (i_cmd.hdr) begin
                r_present  <= '0;
                r_expect   <= i_total_count;
                r_ent_exp  <= i_entry_count;
                r_ent_seen <= '0;
                r_written  <= '0;
                r_psize    <= '0;
                r_root     <= '0;
                r_cur      <= '0;
                r_collect  <= (i_entry_count != 9'd0);
                r_decode   <= 1'b0;
            end

            if (i_cmd.ent) begin
                if ({1'b0, i_entry_symbol} < 9'(ALPHABET)) begin
                    r_present[i_entry_symbol[SW-1:0]] <= 1'b1;
                end
                r_ent_seen <= r_ent_seen + 9'd1;
                if (o_sts.ent_last) begin
                    r_collect <= 1'b0;
                    r_k       <= '0;
                    r_count   <= '0;
                    r_psize   <= '0;
                    r_sv      <= 1'b0;
                end
            end

            if (i_cmd.scan) begin
                r_sv   <= raw_ok;
                r_ssym <= raw;
                r_k    <= r_k + 8'd1;
            end
            if (i_cmd.drain) r_sv <= 1'b0;
            if ((i_cmd.scan || i_cmd.drain) && r_sv) begin
                r_psize <= r_psize + PW'(1);
                r_count <= r_count + NW'(1);
            end

            if (i_cmd.scan_end || i_cmd.rem_wr || i_cmd.merge) begin
                r_j      <= '0;
                r_best_v <= 1'b0;
                r_cmp_v  <= 1'b0;
            end
            if (i_cmd.scan_end) begin
                r_leaf_cnt <= r_count;
                r_have_a   <= 1'b0;
                if (r_count == NW'(1)) begin
                    r_root   <= '0;
                    r_cur    <= '0;
                    r_decode <= 1'b1;
                end
            end

            if (i_cmd.find) begin
                r_cmp_v <= 1'b1;
                r_cmp_j <= r_j;
                r_j     <= r_j + SW'(1);
            end
            if (i_cmd.find_tail) r_cmp_v <= 1'b0;
            if ((i_cmd.find || i_cmd.find_tail) && r_cmp_v && better) begin
                r_best_v   <= 1'b1;
                r_best     <= r_pool_q;
                r_best_idx <= r_cmp_j;
            end

            if (i_cmd.rem_wr) begin
                r_psize <= r_psize - PW'(1);
                if (!r_have_a) begin
                    r_a      <= r_best;
                    r_have_a <= 1'b1;
                end
            end

            if (i_cmd.merge) begin
                r_psize  <= r_psize + PW'(1);
                r_count  <= r_count + NW'(1);
                r_root   <= r_count;
                r_have_a <= 1'b0;
            end
            if (i_cmd.build_end) r_decode <= 1'b1;

            if (i_cmd.byte_load) begin
                r_byte <= i_coded_byte;
                r_bit  <= '0;
            end

            if (i_cmd.walk && !blocked) begin
                r_byte <= {r_byte[6:0], 1'b0};
                r_bit  <= r_bit + 3'd1;
                if (c_leaf) begin
                    if (r_pend_v) begin
                        r_out_v    <= 1'b1;
                        r_out_sym  <= r_pend_sym;
                        r_out_last <= 1'b0;
                        r_out_done <= 1'b0;
                    end
                    r_pend_v   <= 1'b1;
                    r_pend_sym <= c_sym;
                    r_written  <= r_written + 31'd1;
                    if (fin_now) r_fin <= 1'b1;
                end
            end

            if (i_cmd.flush && r_pend_v && out_free) begin
                r_out_v    <= 1'b1;
                r_out_sym  <= r_pend_sym;
                r_out_last <= 1'b1;
                r_out_done <= r_fin;
                r_pend_v   <= 1'b0;
                r_fin      <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.collect    = r_collect;
        o_sts.ent_last   = (r_ent_seen + 9'd1) == r_ent_exp;
        o_sts.scan_last  = (r_k == 8'hFF);
        o_sts.multi      = r_count > NW'(1);
        o_sts.find_last  = r_j == SW'(r_psize - PW'(1));
        o_sts.have_a     = r_have_a;
        o_sts.pool_empty = (r_psize == '0);
        o_sts.walk_ok    = r_decode && (r_root >= r_leaf_cnt) && (r_written < r_expect);
        o_sts.walk_end   = !blocked && ((r_bit == 3'd7) || (c_leaf && fin_now));
        o_sts.flush_done = !r_pend_v || out_free;
    end

    assign o_out_valid   = r_out_v;
    assign o_symbol      = r_out_sym;
    assign o_last_of_run = r_out_last;
    assign o_stream_done = r_out_done;

    `ASSERT_CLK(a_pool_bound, i_clk, i_rst_n, r_psize <= PW'(ALPHABET), "pool overflow")
    `ASSERT_CLK(a_fin_pend, i_clk, i_rst_n, !r_fin || r_pend_v, "final symbol lost")
    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_written <= r_expect, "symbol count overrun")
    `ASSERT_NEXT(a_done_stop, i_clk, i_rst_n, r_out_v && r_out_done && !i_out_stall,
        !r_out_v || !r_out_done, "symbol after stream end")

endmodule

// ===== bench/tb_huffman_tree_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_huffman_tree_decoder
// Self-checking testbench of the Huffman tree decoder.
// ----------------------------------------------------------------------------
// Headers and frequency tables are sent, and the bench builds the same tree
// in its own model. Coded bytes are then decoded by that model, and each
// symbol transaction from the block is checked field by field against the
// oldest prediction. The sender idles in bursts and the receiver stalls on a
// pattern of its own.
module tb_huffman_tree_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES   = 511;
    localparam int LIMIT   = 3000000;

    // Kind code that the block ignores.
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_of_run;
        logic       stream_done;
    } t_sym;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_kind;
    logic [30:0] i_total_count;
    logic [8:0]  i_entry_count;
    logic [7:0]  i_entry_symbol;
    logic [30:0] i_entry_weight;
    logic [7:0]  i_coded_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_symbol;
    logic        o_last_of_run;
    logic        o_stream_done;

    huffman_tree_decoder DUT (.*);

    // Model state.
    logic [30:0] m_weight [256];
    logic        m_present [256];
    logic [39:0] nd_weight [NODES];
    int          nd_left [NODES];
    int          nd_right [NODES];
    logic [7:0]  nd_symbol [NODES];
    logic        nd_leaf [NODES];
    int          pool [$];
    int          root_id, walk_id;
    logic [30:0] sym_total, sym_done;
    logic [8:0]  ent_total, ent_seen;
    logic        collecting, decoding;

    t_sym        expected_syms [$];
    int          errors = 0;
    longint      cycles = 0;
    bit          stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("huffman_tree_decoder verification failed");
            $finish;
        end
    end

    function automatic int take_least();
        int best, a, b, n;
        best = 0;
        for (int i = 1; i < pool.size(); i++) begin
            a = pool[i];
            b = pool[best];
            if (nd_weight[a] < nd_weight[b] || (nd_weight[a] == nd_weight[b] && a < b))
                best = i;
        end
        n = pool[best];
        pool[best] = pool[pool.size() - 1];
        pool.pop_back();
        return n;
    endfunction

    function automatic void build_model_tree();
        int count, raw, a, b;
        count = 0;
        pool.delete();
        for (int k = 0; k < 256; k++) begin
            raw = (k + 128) & 255;
            if (!m_present[raw]) continue;
            nd_weight[count] = {9'd0, m_weight[raw]};
            nd_symbol[count] = raw[7:0];
            nd_leaf[count]   = 1'b1;
            nd_left[count]   = 0;
            nd_right[count]  = 0;
            pool.push_back(count);
            count++;
        end
        if (count == 0) begin
            decoding = 1'b0;
            return;
        end
        while (pool.size() > 1) begin
            a = take_least();
            b = take_least();
            nd_weight[count] = nd_weight[a] + nd_weight[b];
            nd_left[count]   = a;
            nd_right[count]  = b;
            nd_symbol[count] = 8'd0;
            nd_leaf[count]   = 1'b0;
            pool.push_back(count);
            count++;
        end
        root_id  = pool[0];
        walk_id  = root_id;
        decoding = 1'b1;
    endfunction

    // Advances the model by one accepted transaction.
    function automatic void predict_symbols(logic [1:0] kind, logic [30:0] total,
                                            logic [8:0] ecount, logic [7:0] esym,
                                            logic [30:0] ewt, logic [7:0] cbyte);
        t_sym r;
        int   first;
        if (kind == hftd_pkg::KIND_HEADER) begin
            foreach (m_present[i]) m_present[i] = 1'b0;
            sym_total  = total;
            ent_total  = ecount;
            ent_seen   = '0;
            sym_done   = '0;
            root_id    = 0;
            walk_id    = 0;
            decoding   = 1'b0;
            collecting = (ecount != 0);
        end else if (kind == hftd_pkg::KIND_ENTRY) begin
            if (collecting) begin
                m_weight[esym]  = ewt;
                m_present[esym] = 1'b1;
                ent_seen = ent_seen + 9'd1;
                if (ent_seen == ent_total) begin
                    collecting = 1'b0;
                    build_model_tree();
                end
            end
        end else if (kind == hftd_pkg::KIND_CODED) begin
            if (!decoding || nd_leaf[root_id] || sym_done >= sym_total) return;
            first = expected_syms.size();
            for (int i = 7; i >= 0; i--) begin
                walk_id = cbyte[i] ? nd_right[walk_id] : nd_left[walk_id];
                if (nd_leaf[walk_id]) begin
                    sym_done++;
                    r.symbol      = nd_symbol[walk_id];
                    r.last_of_run = 1'b0;
                    r.stream_done = (sym_done == sym_total);
                    expected_syms.push_back(r);
                    walk_id = root_id;
                    if (r.stream_done) break;
                end
            end
            if (expected_syms.size() > first)
                expected_syms[expected_syms.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    // Output checker.
    always @(posedge i_clk) begin
        t_sym e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_syms.size() == 0) begin
                $error("unexpected symbol transaction %0h", o_symbol);
                errors++;
            end else begin
                e = expected_syms.pop_front();
                if (o_symbol !== e.symbol) begin
                    $error("symbol: expected %0h, actual %0h", e.symbol, o_symbol);
                    errors++;
                end
                if (o_last_of_run !== e.last_of_run) begin
                    $error("last_of_run: expected %0b, actual %0b",
                           e.last_of_run, o_last_of_run);
                    errors++;
                end
                if (o_stream_done !== e.stream_done) begin
                    $error("stream_done: expected %0b, actual %0b",
                           e.stream_done, o_stream_done);
                    errors++;
                end
            end
        end
    end

    // Receiver stall pattern: a random mode and a periodic mode alternate.
    always @(negedge i_clk) begin
        if (cycles % 500 == 0) stall_mode <= ~stall_mode;
        if (stall_mode) i_out_stall <= ($urandom_range(0, 3) == 0);
        else i_out_stall <= (cycles % 7 == 3) || (cycles % 7 == 4);
    end

    int burst_left = 0;

    // Valid stays high between transactions of one burst and drops in the gaps.
    task automatic send_item(logic [1:0] kind, logic [30:0] total, logic [8:0] ecount,
                             logic [7:0] esym, logic [30:0] ewt, logic [7:0] cbyte);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                i_kind     <= 2'($urandom);
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_total_count  <= total;
        i_entry_count  <= ecount;
        i_entry_symbol <= esym;
        i_entry_weight <= ewt;
        i_coded_byte   <= cbyte;
        do @(posedge i_clk); while (o_in_stall);
        predict_symbols(kind, total, ecount, esym, ewt, cbyte);
        @(negedge i_clk);
    endtask

    task automatic send_table(logic [30:0] total, int n, int max_weight);
        send_item(hftd_pkg::KIND_HEADER, total, 9'(n), 8'($urandom), 31'($urandom),
                  8'($urandom));
        for (int i = 0; i < n; i++)
            send_item(hftd_pkg::KIND_ENTRY, 31'($urandom), 9'($urandom), 8'($urandom),
                      31'($urandom_range(0, max_weight)), 8'($urandom));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        i_kind     <= 2'($urandom);
        do @(negedge i_clk); while (expected_syms.size() != 0);
    endtask

    task automatic test_directed();
        // Coded byte before any tree, and a header with no entries.
        send_item(hftd_pkg::KIND_CODED, '1, '1, '1, '1, 8'hFF);
        send_item(hftd_pkg::KIND_HEADER, 31'd5, 9'd0, 8'hFF, '1, 8'h00);
        send_item(hftd_pkg::KIND_CODED, '0, '0, '0, '0, 8'h00);
        // One-leaf tree decodes nothing.
        send_item(hftd_pkg::KIND_HEADER, 31'd10, 9'd1, 8'h00, '0, 8'h00);
        send_item(hftd_pkg::KIND_ENTRY, '0, '0, 8'h41, 31'h7FFFFFFF, 8'h00);
        send_item(hftd_pkg::KIND_CODED, '0, '0, '0, '0, 8'hA5);
        // Two symbols at the byte extremes, one at maximum weight; repeated symbol.
        send_item(hftd_pkg::KIND_HEADER, 31'd12, 9'd3, 8'h00, '0, 8'h00);
        send_item(hftd_pkg::KIND_ENTRY, '0, '0, 8'hFF, 31'h7FFFFFFF, 8'h00);
        send_item(hftd_pkg::KIND_ENTRY, '0, '0, 8'h00, 31'd3, 8'h00);
        send_item(hftd_pkg::KIND_ENTRY, '0, '0, 8'hFF, 31'h7FFFFFFF, 8'h00);
        send_item(KIND_RESERVED, '1, '1, '1, '1, 8'hFF);
        send_item(hftd_pkg::KIND_ENTRY, '0, '0, 8'h12, 31'd1, 8'h00);
        send_item(hftd_pkg::KIND_CODED, '0, '0, '0, '0, 8'h00);
        send_item(hftd_pkg::KIND_CODED, '0, '0, '0, '0, 8'hFF);
        send_item(hftd_pkg::KIND_CODED, '0, '0, '0, '0, 8'h5A);
        // Total reached: later bytes ignored.
        send_item(hftd_pkg::KIND_CODED, '0, '0, '0, '0, 8'h33);
        // Zero total.
        send_item(hftd_pkg::KIND_HEADER, 31'd0, 9'd2, 8'h00, '0, 8'h00);
        send_item(hftd_pkg::KIND_ENTRY, '0, '0, 8'h80, 31'd0, 8'h00);
        send_item(hftd_pkg::KIND_ENTRY, '0, '0, 8'h7F, 31'd0, 8'h00);
        send_item(hftd_pkg::KIND_CODED, '0, '0, '0, '0, 8'h0F);
        wait_drained();
    endtask

    task automatic test_random_streams();
        int sent, n, nb;
        sent = 0;
        while (sent < 330) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 256)
                                            : $urandom_range(2, 12);
            if ($urandom_range(0, 19) == 0) n = $urandom_range(0, 2);
            send_table(($urandom_range(0, 9) == 0) ? 31'($urandom)
                                                   : 31'($urandom_range(1, 80)),
                       n, ($urandom_range(0, 1) != 0) ? 7 : 32'h7FFFFFFF);
            nb = $urandom_range(4, 20);
            for (int i = 0; i < nb; i++) begin
                if ($urandom_range(0, 15) == 0)
                    send_item(2'($urandom), 31'($urandom), 9'($urandom),
                              8'($urandom), 31'($urandom), 8'($urandom));
                else
                    send_item(hftd_pkg::KIND_CODED, 31'($urandom), 9'($urandom),
                              8'($urandom), 31'($urandom), 8'($urandom));
            end
            sent += n + nb + 1;
            if ($urandom_range(0, 4) == 0) wait_drained();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        stall_mode = 1'b0;
        i_kind = '0;
        i_total_count = '0;
        i_entry_count = '0;
        i_entry_symbol = '0;
        i_entry_weight = '0;
        i_coded_byte = '0;
        sym_total = '0;
        sym_done = '0;
        ent_total = '0;
        ent_seen = '0;
        collecting = 1'b0;
        decoding = 1'b0;
        root_id = 0;
        walk_id = 0;
        foreach (m_present[i]) m_present[i] = 1'b0;
        foreach (nd_leaf[i]) nd_leaf[i] = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_streams();
        wait_drained();
        repeat (50) @(negedge i_clk);
        if (errors == 0 && expected_syms.size() == 0)
            $display("huffman_tree_decoder verification clean");
        else
            $display("huffman_tree_decoder verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/hftd_pkg.sv
hw/rtl/hftd_ctrl.sv
hw/rtl/hftd_dp.sv
hw/rtl/huffman_tree_decoder.sv
bench/tb_huffman_tree_decoder.sv
